// ===== design/binomial_row_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Binomial row generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_ROW_GENERATOR_CORE_MACROS_SVH
`define BINOMIAL_ROW_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define BRG_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define BRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== design/brg_pkg.sv =====
// ----------------------------------------------------------------------------
// Binomial row generator package
// Payload types, command type and shared constants.
// ----------------------------------------------------------------------------
package brg_pkg;

	localparam int VALUE_W = 60;
	localparam int POS_W   = 6;
	localparam int ROW_W   = 7;
	localparam int COL_W   = 7;

	// Product of a value and a multiplier of at most POS_W bits.
	localparam int PROD_W  = VALUE_W + POS_W;

	localparam int MAX_ROW_DEFAULT     = 64;
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam logic OP_ROW  = 1'b0;
	localparam logic OP_ELEM = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} brg_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic               last;
		logic               error;
	} brg_rsp_t;

	// Work for the back end: run steps 0..k of row n, emit all or only step k.
	typedef struct packed {
		logic             emit_all;
		logic             err;
		logic [POS_W-1:0] n;
		logic [POS_W-1:0] k;
	} brg_cmd_t;

endpackage

// ===== design/binomial_row_generator_core.sv =====
// ----------------------------------------------------------------------------
// Binomial row generator core
// Emits a full row or a single element of Pascal's triangle per request, or one error result.
// ----------------------------------------------------------------------------
//
//   channel | signals                        | moves per transfer
//   --------+--------------------------------+-------------------------------
//   request | req_valid, req_ready, req      | opcode, row, col
//   result  | rsp_valid, rsp_ready, rsp      | value, position, last, error
//
// A row step is a multiply, a bit-serial division over PROD_W (66) quotient bits
// and an output step; an element request skips the output step on all but its last step.
// A two-entry command queue takes new requests while the back end runs; a held
// result stalls the back end at its next output step. Reset clears all control.
// ----------------------------------------------------------------------------
module binomial_row_generator_core import brg_pkg::*; #(
	parameter int MAX_ROW     = MAX_ROW_DEFAULT,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  brg_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output brg_rsp_t rsp
);

	logic     fe_valid;
	logic     fe_ready;
	brg_cmd_t fe_cmd;
	logic     be_valid;
	logic     be_ready;
	brg_cmd_t be_cmd;

	// Classify the request: error, whole row, or one element.
	brg_front #(
		.MAX_ROW (MAX_ROW)
	) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (fe_valid),
		.cmd_ready (fe_ready),
		.cmd       (fe_cmd)
	);

	// Hold classified commands so the front can keep accepting.
	brg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_cmd   (fe_cmd),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready),
		.pop_cmd    (be_cmd)
	);

	// Advance the running product and register each result.
	brg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (be_valid),
		.cmd_ready (be_ready),
		.cmd       (be_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== design/brg_front.sv =====
// ----------------------------------------------------------------------------
// Binomial row generator front end
// Range-check a request and turn it into a back-end command.
// ----------------------------------------------------------------------------
module brg_front import brg_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEFAULT
) (
	input  logic     req_valid,
	output logic     req_ready,
	input  brg_req_t req,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output brg_cmd_t cmd
);

	logic             row_ok;
	logic             col_ok;
	logic [POS_W-1:0] n;
	logic [POS_W-1:0] k_elem;

	assign row_ok = (req.row != '0) && (req.row <= ROW_W'(MAX_ROW));
	assign col_ok = (req.col != '0) && (req.col <= req.row);
	assign n      = POS_W'(req.row - ROW_W'(1));
	assign k_elem = POS_W'(req.col - COL_W'(1));

	always_comb begin
		cmd          = '0;
		cmd.emit_all = (req.opcode == OP_ROW);
		if (!row_ok || (req.opcode == OP_ELEM && !col_ok)) begin
			// Drop to a single error result.
			cmd.err = 1'b1;
		end else if (req.opcode == OP_ROW) begin
			cmd.n = n;
			cmd.k = n;
		end else begin
			cmd.n = n;
			cmd.k = k_elem;
		end
	end

	assign cmd_valid = req_valid;
	assign req_ready = cmd_ready;

endmodule

// ===== design/brg_queue.sv =====
// ----------------------------------------------------------------------------
// Binomial row generator command queue
// Small register FIFO between front and back end.
// ----------------------------------------------------------------------------
module brg_queue import brg_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  brg_cmd_t push_cmd,
	output logic     pop_valid,
	input  logic     pop_ready,
	output brg_cmd_t pop_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	brg_cmd_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/brg_back.sv =====
// ----------------------------------------------------------------------------
// Binomial row generator back end
// Step the running product C(n,i) = C(n,i-1) * (n-i+1) / i with a
// registered multiply and a bit-serial restoring division.
// ----------------------------------------------------------------------------
module brg_back import brg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  brg_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output brg_rsp_t rsp
);

	localparam int CNT_W = $clog2(PROD_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]         state_q;
	logic               emit_all_q;
	logic               err_q;
	logic [POS_W-1:0]   n_q;
	logic [POS_W-1:0]   k_q;
	logic [POS_W-1:0]   i_q;
	logic [VALUE_W-1:0] acc_q;
	logic [PROD_W-1:0]  div_q;
	logic [POS_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rsp_valid_q;
	brg_rsp_t           rsp_q;

	logic [POS_W:0]     trial;
	logic [POS_W:0]     divisor;
	logic               qbit;
	logic [POS_W-1:0]   rem_d;
	logic [PROD_W-1:0]  div_d;
	logic               at_last;
	logic               out_free;

	assign trial    = {rem_q, div_q[PROD_W-1]};
	assign divisor  = {1'b0, i_q};
	assign qbit     = (trial >= divisor);
	assign rem_d    = qbit ? POS_W'(trial - divisor) : POS_W'(trial);
	assign div_d    = {div_q[PROD_W-2:0], qbit};
	assign at_last  = (i_q == k_q);
	assign out_free = !rsp_valid_q || rsp_ready;

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					emit_all_q <= cmd.emit_all;
					err_q      <= cmd.err;
					n_q        <= cmd.n;
					k_q        <= cmd.k;
					i_q        <= '0;
					acc_q      <= cmd.err ? '0 : VALUE_W'(1);
				end
			end
			ST_MUL: begin
				div_q <= PROD_W'(acc_q) * PROD_W'(n_q - i_q);
				rem_q <= '0;
				cnt_q <= CNT_W'(PROD_W - 1);
				i_q   <= i_q + POS_W'(1);
			end
			ST_DIV: begin
				div_q <= div_d;
				rem_q <= rem_d;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					acc_q <= div_d[VALUE_W-1:0];
				end
			end
			ST_OUT: begin
				if (out_free) begin
					rsp_q.value    <= acc_q;
					rsp_q.position <= i_q;
					rsp_q.last     <= at_last;
					rsp_q.error    <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= (cmd.emit_all || cmd.k == '0) ? ST_OUT : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= (emit_all_q || at_last) ? ST_OUT : ST_MUL;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= at_last ? ST_IDLE : ST_MUL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/brg_checker.sv =====
// ----------------------------------------------------------------------------
// Binomial row generator checker
// Port-level checks on the request and result channels, bound to the core.
// ----------------------------------------------------------------------------
`include "binomial_row_generator_core_macros.svh"

module brg_checker import brg_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input brg_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input brg_rsp_t rsp
);

	`BRG_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))
	`BRG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`BRG_ASSERT_IMPL(a_err_shape, rsp_valid && rsp.error, rsp.value == '0 && rsp.last && rsp.position == '0)
	`BRG_ASSERT_IMPL(a_edge_one, rsp_valid && !rsp.error && rsp.position == '0, rsp.value == VALUE_W'(1))
	`BRG_ASSERT_IMPL(a_nonzero, rsp_valid && !rsp.error, rsp.value != '0)

endmodule

bind binomial_row_generator_core brg_checker u_brg_checker (.*);
